// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/sapa_pkg.sv =====
// Types and constants for the subnet address pool allocator.
// No dependencies.
package sapa_pkg;

  localparam int unsigned POOL_ENTRIES_DEF = 256;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PFX_W   = 6;
  localparam int unsigned IDXO_W  = 8;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned RC_W    = 2;

  // entry states are packed sixteen to a memory row
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned ROW_ENTRIES = 16;

  typedef logic [ROW_ENTRIES-1:0][ST_W-1:0] row_t;

  typedef enum logic [1:0] {
    OP_RESERVE  = 2'd0,
    OP_ALLOCATE = 2'd1,
    OP_RECLAIM  = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_e;

  localparam logic [ST_W-1:0] ST_AVAILABLE = 2'd0;
  localparam logic [ST_W-1:0] ST_RESERVED  = 2'd1;
  localparam logic [ST_W-1:0] ST_USED      = 2'd2;

  localparam logic [RC_W-1:0] RC_OK        = 2'd0;
  localparam logic [RC_W-1:0] RC_RANGE     = 2'd1;
  localparam logic [RC_W-1:0] RC_STATE     = 2'd2;
  localparam logic [RC_W-1:0] RC_EXHAUSTED = 2'd3;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_PREFIX = 1'b1;

  localparam logic [PFX_W-1:0] PREFIX_RST = 6'd24;

endpackage

// ===== hdl/subnet_address_pool_allocator_unit.sv =====
// Subnet address pool allocator: top level, one row memory and a sequencer.
// Depends on sapa_pkg and assert_macros.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  command  | start / busy              | operation_i, address_i
//  result   | done_o (one-cycle strobe) | result_code_o, entry_index_o,
//           |                           | granted_address_o, entry_state_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Reserve, reclaim and lookup pass through the check and modify states before
// raising done_o; when the address misses the subnet or the pool, done_o follows the check.
// Allocate: the first-fit scan reads one memory row (sixteen entries) per cycle
// and raises done_o at the first free slot or after the last row.
// After reset a clearing pass over all NUM_ROWS rows holds busy high.
// Results cannot be stalled; config is always ready.
`include "assert_macros.svh"

module subnet_address_pool_allocator_unit #(
  parameter int unsigned POOL_ENTRIES = sapa_pkg::POOL_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [sapa_pkg::ADDR_W-1:0]   address_i,
  output logic                          done_o,
  output logic [sapa_pkg::RC_W-1:0]     result_code_o,
  output logic [sapa_pkg::IDXO_W-1:0]   entry_index_o,
  output logic [sapa_pkg::ADDR_W-1:0]   granted_address_o,
  output logic [sapa_pkg::ST_W-1:0]     entry_state_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [sapa_pkg::ADDR_W-1:0]   cfg_data_i
);

  localparam int unsigned NUM_ROWS =
    (POOL_ENTRIES + sapa_pkg::ROW_ENTRIES - 1) / sapa_pkg::ROW_ENTRIES;
  localparam int unsigned ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned OFF_W  = ROW_AW + sapa_pkg::SLOT_W;
  localparam logic [ROW_AW-1:0] LastRow = ROW_AW'(NUM_ROWS - 1);
  localparam logic [OFF_W:0]    PoolLim = (OFF_W+1)'(POOL_ENTRIES);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MODIFY = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [sapa_pkg::ADDR_W-1:0] base_q;
  logic [sapa_pkg::PFX_W-1:0]  prefix_q;

  sapa_pkg::op_e               op_q;
  logic [sapa_pkg::ADDR_W-1:0] addr_q, mask_q, nb_q;
  logic [OFF_W-1:0]            idx_q, idx_d;
  logic [ROW_AW-1:0]           row_q, row_d;
  logic [ROW_AW-1:0]           clr_q, clr_d;

  logic                        done_q, done_d;
  logic [sapa_pkg::RC_W-1:0]   rc_q, rc_d;
  logic [sapa_pkg::IDXO_W-1:0] ridx_q, ridx_d;
  logic [sapa_pkg::ADDR_W-1:0] rgrant_q, rgrant_d;
  logic [sapa_pkg::ST_W-1:0]   rst_q, rst_d;

  // row memory
  sapa_pkg::row_t    pool_mem_q [NUM_ROWS];
  sapa_pkg::row_t    rd_q;
  logic              mem_re, mem_we;
  logic [ROW_AW-1:0] mem_raddr, mem_waddr;
  sapa_pkg::row_t    mem_wdata;

  logic                        accept;
  logic [sapa_pkg::PFX_W-1:0]  pfx_clamped;
  logic [sapa_pkg::ADDR_W-1:0] mask_now;
  logic [sapa_pkg::ADDR_W-1:0] off;
  logic                        in_pool;

  logic [sapa_pkg::SLOT_W-1:0] slot;
  logic [sapa_pkg::ST_W-1:0]   cur_st;
  sapa_pkg::row_t              mod_row;

  logic [sapa_pkg::ROW_ENTRIES-1:0] free_vec;
  logic                             hit;
  logic [sapa_pkg::SLOT_W-1:0]      hit_slot;
  logic [OFF_W-1:0]                 hit_idx;
  sapa_pkg::row_t                   alloc_row;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign done_o            = done_q;
  assign result_code_o     = rc_q;
  assign entry_index_o     = ridx_q;
  assign granted_address_o = rgrant_q;
  assign entry_state_o     = rst_q;

  // subnet mask from the prefix; zero prefix gives an empty mask
  always_comb begin
    pfx_clamped = (prefix_q > 6'd32) ? 6'd32 : prefix_q;
    if (pfx_clamped == '0) begin
      mask_now = '0;
    end else begin
      mask_now = {sapa_pkg::ADDR_W{1'b1}} << (6'd32 - pfx_clamped);
    end
  end

  assign off     = addr_q - nb_q;
  assign in_pool = ((addr_q & mask_q) == nb_q) && (off < 32'(POOL_ENTRIES));

  // single-entry update for reserve / reclaim
  assign slot   = idx_q[sapa_pkg::SLOT_W-1:0];
  assign cur_st = rd_q[slot];
  always_comb begin
    mod_row = rd_q;
    case (op_q)
      sapa_pkg::OP_RESERVE: mod_row[slot] = sapa_pkg::ST_RESERVED;
      sapa_pkg::OP_RECLAIM: mod_row[slot] = sapa_pkg::ST_AVAILABLE;
      default:              mod_row[slot] = cur_st;
    endcase
  end

  // first free slot of the row under scan; skip the network address and
  // slots past the end of the pool
  always_comb begin
    logic [OFF_W-1:0] g;
    hit_slot = '0;
    for (int s = 0; s < int'(sapa_pkg::ROW_ENTRIES); s++) begin
      g = {row_q, sapa_pkg::SLOT_W'(s)};
      free_vec[s] = (rd_q[s] == sapa_pkg::ST_AVAILABLE) && (g != '0) &&
                    ({1'b0, g} < PoolLim);
    end
    for (int s = int'(sapa_pkg::ROW_ENTRIES) - 1; s >= 0; s--) begin
      if (free_vec[s]) begin
        hit_slot = sapa_pkg::SLOT_W'(s);
      end
    end
    hit       = |free_vec;
    hit_idx   = {row_q, hit_slot};
    alloc_row = rd_q;
    alloc_row[hit_slot] = sapa_pkg::ST_USED;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    row_d     = row_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    rc_d      = rc_q;
    ridx_d    = ridx_q;
    rgrant_d  = rgrant_q;
    rst_d     = rst_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastRow) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (sapa_pkg::op_e'(operation_i) == sapa_pkg::OP_ALLOCATE) begin
            mem_re  = 1'b1;
            row_d   = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (in_pool) begin
          idx_d     = off[OFF_W-1:0];
          mem_re    = 1'b1;
          mem_raddr = off[OFF_W-1:sapa_pkg::SLOT_W];
          state_d   = S_MODIFY;
        end else begin
          done_d   = 1'b1;
          rc_d     = sapa_pkg::RC_RANGE;
          ridx_d   = '0;
          rgrant_d = '0;
          rst_d    = '0;
          state_d  = S_IDLE;
        end
      end
      S_MODIFY: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if ((op_q == sapa_pkg::OP_RESERVE && cur_st != sapa_pkg::ST_AVAILABLE) ||
            (op_q == sapa_pkg::OP_RECLAIM && cur_st != sapa_pkg::ST_USED)) begin
          rc_d     = sapa_pkg::RC_STATE;
          ridx_d   = '0;
          rgrant_d = '0;
          rst_d    = '0;
        end else begin
          mem_we    = (op_q != sapa_pkg::OP_LOOKUP);
          mem_waddr = idx_q[OFF_W-1:sapa_pkg::SLOT_W];
          mem_wdata = mod_row;
          rc_d      = sapa_pkg::RC_OK;
          ridx_d    = sapa_pkg::IDXO_W'(idx_q);
          rgrant_d  = nb_q + 32'(idx_q);
          rst_d     = mod_row[slot];
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = row_q;
          mem_wdata = alloc_row;
          done_d    = 1'b1;
          rc_d      = sapa_pkg::RC_OK;
          ridx_d    = 8'(32'(hit_idx));
          rgrant_d  = nb_q + 32'(hit_idx);
          rst_d     = sapa_pkg::ST_USED;
          state_d   = S_IDLE;
        end else if (row_q == LastRow) begin
          done_d   = 1'b1;
          rc_d     = sapa_pkg::RC_EXHAUSTED;
          ridx_d   = '0;
          rgrant_d = '0;
          rst_d    = '0;
          state_d  = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = row_q + 1'b1;
          row_d     = row_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      base_q   <= '0;
      prefix_q <= sapa_pkg::PREFIX_RST;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == sapa_pkg::CFG_BASE) begin
          base_q <= cfg_data_i;
        end else begin
          prefix_q <= cfg_data_i[sapa_pkg::PFX_W-1:0];
        end
      end
    end
  end

  // command word and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= sapa_pkg::op_e'(operation_i);
      addr_q <= address_i;
      mask_q <= mask_now;
      nb_q   <= base_q & mask_now;
    end
    idx_q    <= idx_d;
    row_q    <= row_d;
    rc_q     <= rc_d;
    ridx_q   <= ridx_d;
    rgrant_q <= rgrant_d;
    rst_q    <= rst_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= pool_mem_q[mem_raddr];
    end
  end

  `ASSERT_RST(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `ASSERT_RST(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `ASSERT_RST(a_fail_zero, clk_i, rst_ni,
    (done_o && result_code_o != sapa_pkg::RC_OK) |->
    (entry_index_o == '0 && granted_address_o == '0 && entry_state_o == '0))
  `ASSERT_RST(a_clear_quiet, clk_i, rst_ni, (state_q == S_CLEAR) |-> !done_o)

endmodule

// ===== dv/subnet_address_pool_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for subnet_address_pool_allocator_unit: directed, exhaustion and random command words,
// each result checked against an in-bench pool model. Depends on sapa_pkg and the unit's RTL.
module subnet_address_pool_allocator_unit_tb;

  localparam int unsigned POOL       = sapa_pkg::POOL_ENTRIES_DEF;
  localparam int unsigned NUM_ROWS   = POOL / sapa_pkg::ROW_ENTRIES;
  localparam int unsigned PHASE_LEN  = 190;
  localparam int unsigned CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [sapa_pkg::RC_W-1:0]   code;
    logic [sapa_pkg::IDXO_W-1:0] index;
    logic [sapa_pkg::ADDR_W-1:0] addr;
    logic [sapa_pkg::ST_W-1:0]   st;
  } grant_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  operation_i = sapa_pkg::OP_LOOKUP;
  logic [sapa_pkg::ADDR_W-1:0] address_i = '0;
  logic                        done_o;
  logic [sapa_pkg::RC_W-1:0]   result_code_o;
  logic [sapa_pkg::IDXO_W-1:0] entry_index_o;
  logic [sapa_pkg::ADDR_W-1:0] granted_address_o;
  logic [sapa_pkg::ST_W-1:0]   entry_state_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic                        cfg_index_i = sapa_pkg::CFG_BASE;
  logic [sapa_pkg::ADDR_W-1:0] cfg_data_i = '0;

  // pool model
  logic [sapa_pkg::ST_W-1:0]   pool_state [POOL];
  logic [sapa_pkg::ADDR_W-1:0] base_reg = '0;
  logic [sapa_pkg::PFX_W-1:0]  prefix_reg = sapa_pkg::PREFIX_RST;
  grant_t                      grants_due [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  subnet_address_pool_allocator_unit #(.POOL_ENTRIES(POOL)) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .done_o            (done_o),
    .result_code_o     (result_code_o),
    .entry_index_o     (entry_index_o),
    .granted_address_o (granted_address_o),
    .entry_state_o     (entry_state_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < POOL; i++) pool_state[i] = sapa_pkg::ST_AVAILABLE;
  end

  function automatic logic [sapa_pkg::ADDR_W-1:0] subnet_mask();
    int unsigned p;
    p = prefix_reg;
    if (p == 0) return '0;
    if (p > 32) p = 32;
    return {sapa_pkg::ADDR_W{1'b1}} << (32 - p);
  endfunction

  function automatic logic [sapa_pkg::ADDR_W-1:0] subnet_base();
    return base_reg & subnet_mask();
  endfunction

  // applies one command to the pool model and returns the word it should produce
  function automatic grant_t next_grant(sapa_pkg::op_e op, logic [sapa_pkg::ADDR_W-1:0] addr);
    grant_t                      g;
    logic [sapa_pkg::ADDR_W-1:0] nb;
    logic [sapa_pkg::ADDR_W-1:0] off;
    g = '0;
    g.code = sapa_pkg::RC_OK;
    nb = subnet_base();
    if (op == sapa_pkg::OP_ALLOCATE) begin
      for (int unsigned i = 1; i < POOL; i++) begin
        if (pool_state[i] == sapa_pkg::ST_AVAILABLE) begin
          pool_state[i] = sapa_pkg::ST_USED;
          g.index = i[sapa_pkg::IDXO_W-1:0];
          g.addr  = nb + i;
          g.st    = sapa_pkg::ST_USED;
          return g;
        end
      end
      g.code = sapa_pkg::RC_EXHAUSTED;
      return g;
    end
    off = addr - nb;
    if ((addr & subnet_mask()) != nb || off >= POOL) begin
      g.code = sapa_pkg::RC_RANGE;
      return g;
    end
    if (op == sapa_pkg::OP_RESERVE) begin
      if (pool_state[off] != sapa_pkg::ST_AVAILABLE) begin
        g.code = sapa_pkg::RC_STATE;
        return g;
      end
      pool_state[off] = sapa_pkg::ST_RESERVED;
    end else if (op == sapa_pkg::OP_RECLAIM) begin
      if (pool_state[off] != sapa_pkg::ST_USED) begin
        g.code = sapa_pkg::RC_STATE;
        return g;
      end
      pool_state[off] = sapa_pkg::ST_AVAILABLE;
    end
    g.index = off[sapa_pkg::IDXO_W-1:0];
    g.addr  = nb + off;
    g.st    = pool_state[off];
    return g;
  endfunction

  function automatic int pick_state_index(logic [sapa_pkg::ST_W-1:0] st);
    int hits [$];
    for (int i = 0; i < POOL; i++) if (pool_state[i] == st) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int first_available();
    for (int i = 1; i < POOL; i++) if (pool_state[i] == sapa_pkg::ST_AVAILABLE) return i;
    return 0;
  endfunction

  // mostly pool members, some just past the pool or one bit off the subnet
  function automatic logic [sapa_pkg::ADDR_W-1:0] random_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return subnet_base() + $urandom_range(0, POOL - 1);
    if (r < 80) return subnet_base() + $urandom_range(POOL, 4 * POOL);
    if (r < 88) return (subnet_base() + $urandom_range(0, POOL - 1)) ^
                       (32'h1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  function automatic int idle_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_word(sapa_pkg::op_e op, logic [sapa_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    grants_due.push_back(next_grant(op, addr));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants_due.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  // writes base then prefix, valid held across both words
  task automatic set_subnet(logic [sapa_pkg::ADDR_W-1:0] base,
                            logic [sapa_pkg::ADDR_W-1:0] pfx_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sapa_pkg::CFG_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    base_reg = base;
    cfg_index_i <= sapa_pkg::CFG_PREFIX;
    cfg_data_i  <= pfx_word;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    prefix_reg = pfx_word[sapa_pkg::PFX_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    grant_t exp;
    if (rst_ni && done_o === 1'b1) begin
      if (grants_due.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatch_count++;
      end else begin
        exp = grants_due.pop_front();
        if (result_code_o !== exp.code) begin
          $error("result_code: expected %0d, got %0d", exp.code, result_code_o);
          mismatch_count++;
        end
        if (entry_index_o !== exp.index) begin
          $error("entry_index: expected %0d, got %0d", exp.index, entry_index_o);
          mismatch_count++;
        end
        if (granted_address_o !== exp.addr) begin
          $error("granted_address: expected %08h, got %08h", exp.addr, granted_address_o);
          mismatch_count++;
        end
        if (entry_state_o !== exp.st) begin
          $error("entry_state: expected %0d, got %0d", exp.st, entry_state_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // reset values, every operation, wrong-state and range failures, then odd prefixes
  task automatic test_directed();
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_0000);
    send_word(sapa_pkg::OP_RESERVE, 32'h0000_0000);
    send_word(sapa_pkg::OP_RESERVE, 32'h0000_0000);
    send_word(sapa_pkg::OP_ALLOCATE, 32'hFFFF_FFFF);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_0001);
    send_word(sapa_pkg::OP_RECLAIM, 32'h0000_0001);
    send_word(sapa_pkg::OP_RECLAIM, 32'h0000_0001);
    send_word(sapa_pkg::OP_RECLAIM, 32'h0000_0000);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_00FF);
    send_word(sapa_pkg::OP_RESERVE, 32'h0000_00FF);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_0100);
    send_word(sapa_pkg::OP_RECLAIM, 32'hFFFF_FFFF);
    send_word(sapa_pkg::OP_ALLOCATE, 32'h0000_0000);
    // host prefix: allocate walks past the single-address subnet and wraps
    drain();
    set_subnet(32'hFFFF_FFFF, 32'd32);
    send_word(sapa_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
    send_word(sapa_pkg::OP_ALLOCATE, 32'h5555_AAAA);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_0000);
    // zero prefix: whole address space is the subnet
    drain();
    set_subnet(32'hDEAD_BEEF, 32'd0);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_00FF);
    send_word(sapa_pkg::OP_RESERVE, 32'h0000_0100);
    send_word(sapa_pkg::OP_LOOKUP, 32'hDEAD_BEEF);
    // prefix beyond 32 behaves as a host prefix
    drain();
    set_subnet(32'h8000_0000, 32'hFFFF_FFFF);
    send_word(sapa_pkg::OP_RESERVE, 32'h8000_0000);
    send_word(sapa_pkg::OP_LOOKUP, 32'h8000_0001);
    drain();
    set_subnet(32'h1234_5678, 32'd1);
    send_word(sapa_pkg::OP_LOOKUP, 32'h7FFF_FFFF);
    send_word(sapa_pkg::OP_LOOKUP, 32'h0000_000A);
    send_word(sapa_pkg::OP_RECLAIM, 32'h0000_0001);
  endtask

  // fill the pool through the first-fit scan, overrun it, then free and refill holes
  task automatic test_pool_exhaustion();
    int idx;
    drain();
    set_subnet(32'h0A00_0037, 32'd24);
    gaps_on = 1'b1;
    while (first_available() != 0) send_word(sapa_pkg::OP_ALLOCATE, $urandom);
    repeat (3) send_word(sapa_pkg::OP_ALLOCATE, $urandom);
    repeat (20) begin
      idx = pick_state_index(sapa_pkg::ST_USED);
      if (idx < 0) idx = 0;
      send_word(sapa_pkg::OP_RECLAIM, subnet_base() + idx);
    end
    repeat (24) send_word(sapa_pkg::OP_ALLOCATE, $urandom);
  endtask

  task automatic test_random_traffic();
    int                          pfx_plan [8];
    int                          pfx;
    int                          pick;
    int                          idx;
    logic [sapa_pkg::ADDR_W-1:0] base;
    logic [sapa_pkg::ADDR_W-1:0] pfx_word;
    logic [sapa_pkg::ADDR_W-1:0] addr;
    sapa_pkg::op_e               op;
    pfx_plan = '{24, 1, 32, 0, 45, 28, 16, -1};
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      pfx = (pfx_plan[ph] < 0) ? $urandom_range(0, 63) : pfx_plan[ph];
      base = (ph == 2) ? 32'hFFFF_FFFF : $urandom;
      pfx_word = ($urandom_range(0, 1) ? ($urandom & ~32'h3F) : 32'h0) | pfx;
      set_subnet(base, pfx_word);
      for (int n = 0; n < PHASE_LEN; n++) begin
        gaps_on = ((n / 40) % 3) != 2;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          op   = sapa_pkg::OP_ALLOCATE;
          addr = $urandom;
        end else if (pick < 55) begin
          op  = sapa_pkg::OP_RECLAIM;
          idx = pick_state_index(sapa_pkg::ST_USED);
          addr = (idx >= 0 && $urandom_range(0, 4) != 0) ? subnet_base() + idx
                                                          : random_address();
        end else if (pick < 62) begin
          op   = sapa_pkg::OP_RESERVE;
          addr = random_address();
        end else begin
          op   = sapa_pkg::OP_LOOKUP;
          addr = random_address();
        end
        send_word(op, addr);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_pool_exhaustion();
    test_random_traffic();
    drain();
    repeat (NUM_ROWS + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
